[rtl/core/wbrf_pkg.sv]
package wbrf_pkg;

    // frame geometry and fixed thresholds
    localparam int unsigned IMG_WIDTH    = 640;
    localparam int unsigned IMG_HEIGHT   = 480;
    localparam logic [7:0]  BRIGHT_LEVEL = 8'd128;
    localparam logic [9:0]  WIDTH_MAX    = 10'd1023;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_BOTTOM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_COLUMN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TOL    = 3'd6;

    // configuration reset values
    localparam logic [9:0] RST_ROI_LEFT      = 10'd160;
    localparam logic [9:0] RST_ROI_RIGHT     = 10'd480;
    localparam logic [8:0] RST_ROI_TOP       = 9'd168;
    localparam logic [8:0] RST_ROI_BOTTOM    = 9'd360;
    localparam logic [9:0] RST_REF_COLUMN    = 10'd320;
    localparam logic [9:0] RST_MIN_RUN_WIDTH = 10'd8;
    localparam logic [9:0] RST_CENTER_TOL    = 10'd4;

    localparam int unsigned CFG_DATA_W = 10;

    typedef struct packed {
        logic [9:0] roi_left;
        logic [9:0] roi_right;
        logic [8:0] roi_top;
        logic [8:0] roi_bottom;
        logic [9:0] reference_column;
        logic [9:0] min_run_width;
        logic [9:0] center_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [7:0] pixel;
        logic [9:0] column;
        logic [8:0] row;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic       found;
        logic [9:0] run_left;
        logic [9:0] run_right;
        logic [9:0] center_col;
        logic [8:0] center_row;
        logic [9:0] run_width;
    } t_result;

    // classified pixel as it travels through the queue
    typedef struct packed {
        logic [9:0] column;
        logic [8:0] row;
        logic       in_roi;
        logic       bright;
        logic       at_left;
        logic       at_right;
        logic       frame_end;
    } t_cls;

endpackage

[rtl/core/wbrf_front.sv]
module wbrf_front import wbrf_pkg::*; (
    input  logic   i_valid,
    input  t_pixel i_data,
    input  t_cfg   i_cfg,
    input  logic   i_full,
    output logic   o_stall,
    output logic   o_push,
    output t_cls   o_cls
);

    logic in_roi;

    assign in_roi = (i_data.column >= i_cfg.roi_left) && (i_data.column <= i_cfg.roi_right)
                 && (i_data.row >= i_cfg.roi_top) && (i_data.row <= i_cfg.roi_bottom);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls.column    = i_data.column;
        o_cls.row       = i_data.row;
        o_cls.in_roi    = in_roi;
        o_cls.bright    = i_data.pixel > BRIGHT_LEVEL;
        o_cls.at_left   = i_data.column == i_cfg.roi_left;
        o_cls.at_right  = i_data.column == i_cfg.roi_right;
        o_cls.frame_end = i_data.frame_end;
    end

endmodule

[rtl/core/wbrf_queue.sv]
module wbrf_queue import wbrf_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

endmodule

[rtl/core/wbrf_back.sv]
module wbrf_back import wbrf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_cls    i_data,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    typedef struct packed {
        logic       frame_end;
        logic       ok;
        logic [9:0] left;
        logic [9:0] right;
        logic [8:0] row;
        logic [9:0] center;
        logic [9:0] width;
        logic [9:0] error;
    } t_cand;

    // run tracker state
    logic       r_in_run;
    logic [9:0] r_run_begin;
    // candidate stage
    logic       r_s1_valid;
    t_cand      r_s1;
    // best run so far
    logic [9:0] r_best_left;
    logic [9:0] r_best_right;
    logic [8:0] r_best_row;
    logic [9:0] r_best_width;
    logic [9:0] r_best_error;
    logic [9:0] r_best_center;
    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic        adv;
    logic        ir0;
    logic        starting;
    logic        ir1;
    logic        close_dark;
    logic        close_edge;
    logic [9:0]  first;
    logic [9:0]  last;
    logic        drop;
    logic [10:0] span;
    logic [10:0] sum;
    logic [9:0]  center;
    logic [9:0]  error;
    t_cand       cand;
    logic        n_in_run;
    logic [9:0]  n_run_begin;

    logic        qual;
    logic        better;
    logic        take;
    logic [9:0]  n_best_left;
    logic [9:0]  n_best_right;
    logic [8:0]  n_best_row;
    logic [9:0]  n_best_width;
    logic [9:0]  n_best_error;
    logic [9:0]  n_best_center;
    t_result     n_out;

    // the back holds only while a frame end waits behind a stalled result
    assign adv   = !(r_s1_valid && r_s1.frame_end && r_out_valid && i_stall);
    assign o_pop = adv && i_valid;

    // run tracking
    always_comb begin
        ir0        = r_in_run && !i_data.at_left;
        starting   = i_data.bright && !ir0;
        ir1        = ir0 || starting;
        first      = starting ? i_data.column : r_run_begin;
        close_dark = ir1 && !i_data.bright;
        close_edge = ir1 && i_data.bright && i_data.at_right;
        last       = close_dark ? i_data.column - 10'd1 : i_data.column;
        drop       = (close_dark && i_data.column == 10'd0) || (last < first);
        span       = {1'b0, last} - {1'b0, first} + 11'd1;
        sum        = {1'b0, first} + {1'b0, last};
        center     = sum[10:1];
        error      = (center >= i_cfg.reference_column) ? center - i_cfg.reference_column
                                                        : i_cfg.reference_column - center;

        cand.frame_end = i_data.frame_end;
        cand.ok        = i_data.in_roi && (close_dark || close_edge) && !drop;
        cand.left      = first;
        cand.right     = last;
        cand.row       = i_data.row;
        cand.center    = center;
        cand.width     = span[10] ? WIDTH_MAX : span[9:0];
        cand.error     = error;

        n_in_run    = i_data.in_roi && ir1 && !close_dark && !close_edge;
        n_run_begin = (i_data.in_roi && starting) ? i_data.column : r_run_begin;
        if (i_data.frame_end) begin
            n_in_run    = 1'b0;
            n_run_begin = '0;
        end
    end

    // best run selection and frame result
    always_comb begin
        qual   = r_s1.ok && (r_s1.width >= i_cfg.min_run_width)
              && (r_s1.error <= i_cfg.center_tolerance);
        better = (r_s1.width > r_best_width)
              || ((r_s1.width == r_best_width) && (r_s1.error < r_best_error));
        take   = qual && better;

        n_best_left   = take ? r_s1.left   : r_best_left;
        n_best_right  = take ? r_s1.right  : r_best_right;
        n_best_row    = take ? r_s1.row    : r_best_row;
        n_best_width  = take ? r_s1.width  : r_best_width;
        n_best_error  = take ? r_s1.error  : r_best_error;
        n_best_center = take ? r_s1.center : r_best_center;

        n_out = '0;
        if (n_best_width != '0) begin
            n_out.found      = 1'b1;
            n_out.run_left   = n_best_left;
            n_out.run_right  = n_best_right;
            n_out.center_col = n_best_center;
            n_out.center_row = n_best_row;
            n_out.run_width  = n_best_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run      <= 1'b0;
            r_run_begin   <= '0;
            r_s1_valid    <= 1'b0;
            r_best_left   <= '0;
            r_best_right  <= '0;
            r_best_row    <= '0;
            r_best_width  <= '0;
            r_best_error  <= 10'(IMG_WIDTH);
            r_best_center <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_run    <= n_in_run;
                r_run_begin <= n_run_begin;
            end
            if (adv) begin
                r_s1_valid <= i_valid;
            end
            if (adv && r_s1_valid) begin
                if (r_s1.frame_end) begin
                    r_best_left   <= '0;
                    r_best_right  <= '0;
                    r_best_row    <= '0;
                    r_best_width  <= '0;
                    r_best_error  <= 10'(IMG_WIDTH);
                    r_best_center <= '0;
                end else begin
                    r_best_left   <= n_best_left;
                    r_best_right  <= n_best_right;
                    r_best_row    <= n_best_row;
                    r_best_width  <= n_best_width;
                    r_best_error  <= n_best_error;
                    r_best_center <= n_best_center;
                end
            end
            if (adv && r_s1_valid && r_s1.frame_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= cand;
        end
        if (adv && r_s1_valid && r_s1.frame_end) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/core/widest_bright_run_finder_unit.sv]
// a frame result follows its last pixel through queue, candidate stage and result register
// one pixel per cycle while the queue has room, set by the run tracker and best-run compare
// a four-entry queue lets the front keep taking pixels while a result waits on a stalled output
// reset: synchronous, active low; clears the queue, run state, best run and result valid,
// and loads the configuration registers with their defaults
module widest_bright_run_finder_unit import wbrf_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pixel                i_in_data,
    // result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_result               o_out_data,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers, held across frames
    t_cfg r_cfg;

    // front to queue
    logic fr_push;
    t_cls fr_cls;
    logic q_full;
    // queue to back
    logic q_valid;
    t_cls q_data;
    logic bk_pop;

    // register writes; an index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roi_left         <= RST_ROI_LEFT;
            r_cfg.roi_right        <= RST_ROI_RIGHT;
            r_cfg.roi_top          <= RST_ROI_TOP;
            r_cfg.roi_bottom       <= RST_ROI_BOTTOM;
            r_cfg.reference_column <= RST_REF_COLUMN;
            r_cfg.min_run_width    <= RST_MIN_RUN_WIDTH;
            r_cfg.center_tolerance <= RST_CENTER_TOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROI_LEFT:      r_cfg.roi_left         <= i_cfg_data;
                CFG_ROI_RIGHT:     r_cfg.roi_right        <= i_cfg_data;
                CFG_ROI_TOP:       r_cfg.roi_top          <= i_cfg_data[8:0];
                CFG_ROI_BOTTOM:    r_cfg.roi_bottom       <= i_cfg_data[8:0];
                CFG_REF_COLUMN:    r_cfg.reference_column <= i_cfg_data;
                CFG_MIN_RUN_WIDTH: r_cfg.min_run_width    <= i_cfg_data;
                CFG_CENTER_TOL:    r_cfg.center_tolerance <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: takes each pixel transaction and tags it against the search rectangle and brightness level
    wbrf_front u_front (
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (fr_push),
        .o_cls   (fr_cls)
    );

    // short queue decoupling the front from a back held by the output
    wbrf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cls),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // back: tracks runs, measures closed ones, keeps the widest and
    // registers the frame result for the output transaction
    wbrf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (bk_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
